// ===== hdl/fdm_pkg.sv =====
// shared types, constants and width helpers for the floored divider
package fdm_pkg;

	// default for the widest operand width
	localparam int DEF_MAX_WIDTH = 32;

	// operand fields on the stream are this wide
	localparam int FIELD_W = 32;

	// width select codes
	localparam logic [1:0] WSEL_8  = 2'd0;
	localparam logic [1:0] WSEL_16 = 2'd1;

	// classification that travels with each request
	typedef struct packed {
		logic div_zero;
		logic ovf;
		logic neg_a;
		logic neg_b;
	} fdm_flags_t;

	// wide operand width, capped at the field width
	function automatic int wide_width(int mw);
		return (mw > FIELD_W) ? FIELD_W : mw;
	endfunction

	// datapath width, never below the fixed 16-bit mode
	function automatic int data_width(int mw);
		return (wide_width(mw) < 16) ? 16 : wide_width(mw);
	endfunction

endpackage

// ===== hdl/fdm_front.sv =====
// front end: takes requests, sign-extends operands, classifies and takes magnitudes
module fdm_front #(
	parameter int MAX_WIDTH = fdm_pkg::DEF_MAX_WIDTH,
	localparam int DW = fdm_pkg::data_width(MAX_WIDTH)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [63:0]              s_tdata,   // dividend[31:0], divisor[63:32]
	input  logic [1:0]               s_tuser,   // width_sel[1:0]
	output logic                     out_valid,
	input  logic                     out_ready,
	output fdm_pkg::fdm_flags_t      out_flags,
	output logic [DW-1:0]            out_mag_a,
	output logic [DW-1:0]            out_mag_b
);

	localparam int WW = fdm_pkg::wide_width(MAX_WIDTH);

	logic [31:0] dividend;
	logic [31:0] divisor;

	logic signed [7:0]    a8;
	logic signed [7:0]    b8;
	logic signed [15:0]   a16;
	logic signed [15:0]   b16;
	logic signed [WW-1:0] aw;
	logic signed [WW-1:0] bw;

	logic signed [DW-1:0] a_val;
	logic signed [DW-1:0] b_val;
	logic                 a_most_neg;

	fdm_pkg::fdm_flags_t flags;
	logic [DW-1:0]       mag_a;
	logic [DW-1:0]       mag_b;

	logic                s1_valid_q;
	fdm_pkg::fdm_flags_t flags_s1;
	logic [DW-1:0]       mag_a_s1;
	logic [DW-1:0]       mag_b_s1;

	assign dividend = s_tdata[31:0];
	assign divisor  = s_tdata[63:32];

	assign a8  = dividend[7:0];
	assign b8  = divisor[7:0];
	assign a16 = dividend[15:0];
	assign b16 = divisor[15:0];
	assign aw  = dividend[WW-1:0];
	assign bw  = divisor[WW-1:0];

	// sign extension at the selected width
	always_comb begin
		case (s_tuser)
			fdm_pkg::WSEL_8: begin
				a_val      = DW'(a8);
				b_val      = DW'(b8);
				a_most_neg = (dividend[7:0] == {1'b1, 7'b0});
			end
			fdm_pkg::WSEL_16: begin
				a_val      = DW'(a16);
				b_val      = DW'(b16);
				a_most_neg = (dividend[15:0] == {1'b1, 15'b0});
			end
			default: begin
				a_val      = DW'(aw);
				b_val      = DW'(bw);
				a_most_neg = (dividend[WW-1:0] == {1'b1, {(WW-1){1'b0}}});
			end
		endcase
	end

	// special cases and magnitudes
	always_comb begin
		flags.div_zero = (b_val == '0);
		flags.ovf      = a_most_neg && (b_val == '1);
		flags.neg_a    = a_val[DW-1];
		flags.neg_b    = b_val[DW-1];
		mag_a          = flags.neg_a ? (DW'(0) - a_val) : a_val;
		mag_b          = flags.neg_b ? (DW'(0) - b_val) : b_val;
	end

	assign s_tready = !s1_valid_q || out_ready;

	// request holding register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			flags_s1 <= flags;
			mag_a_s1 <= mag_a;
			mag_b_s1 <= mag_b;
		end
	end

	assign out_valid = s1_valid_q;
	assign out_flags = flags_s1;
	assign out_mag_a = mag_a_s1;
	assign out_mag_b = mag_b_s1;

endmodule

// ===== hdl/fdm_fifo.sv =====
// two-entry queue between the front end and the divider pipeline
module fdm_fifo #(
	parameter int MAX_WIDTH = fdm_pkg::DEF_MAX_WIDTH,
	localparam int DW = fdm_pkg::data_width(MAX_WIDTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  fdm_pkg::fdm_flags_t in_flags,
	input  logic [DW-1:0]       in_mag_a,
	input  logic [DW-1:0]       in_mag_b,
	output logic                out_valid,
	input  logic                out_ready,
	output fdm_pkg::fdm_flags_t out_flags,
	output logic [DW-1:0]       out_mag_a,
	output logic [DW-1:0]       out_mag_b
);

	localparam int DEPTH = 2;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	fdm_pkg::fdm_flags_t flags_q [DEPTH];
	logic [DW-1:0]       mag_a_q [DEPTH];
	logic [DW-1:0]       mag_b_q [DEPTH];

	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	logic push;
	logic pop;

	assign in_ready  = (count_q != CW'(DEPTH));
	assign out_valid = (count_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			flags_q[wr_ptr_q] <= in_flags;
			mag_a_q[wr_ptr_q] <= in_mag_a;
			mag_b_q[wr_ptr_q] <= in_mag_b;
		end
	end

	assign out_flags = flags_q[rd_ptr_q];
	assign out_mag_a = mag_a_q[rd_ptr_q];
	assign out_mag_b = mag_b_q[rd_ptr_q];

endmodule

// ===== hdl/fdm_back.sv =====
// back end: pipelined restoring divider, one quotient bit a stage, then floor fix-up
module fdm_back #(
	parameter int MAX_WIDTH = fdm_pkg::DEF_MAX_WIDTH,
	localparam int DW = fdm_pkg::data_width(MAX_WIDTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  fdm_pkg::fdm_flags_t in_flags,
	input  logic [DW-1:0]       in_mag_a,
	input  logic [DW-1:0]       in_mag_b,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [63:0]         m_tdata,   // quotient[31:0], modulo[63:32]
	output logic [1:0]          m_tuser    // div_by_zero[0], overflow[1]
);

	// stage k holds the state after k quotient bits
	logic                valid_s [1:DW];
	fdm_pkg::fdm_flags_t flags_s [1:DW];
	logic [DW-1:0]       rem_s   [1:DW];
	logic [DW-1:0]       quo_s   [1:DW];
	logic [DW-1:0]       den_s   [1:DW];

	logic                m_tvalid_q;
	logic [31:0]         quotient_q;
	logic [31:0]         modulo_q;
	logic                div_zero_q;
	logic                ovf_q;

	logic adv;

	// whole pipeline moves together when the output can take a result
	assign adv      = !m_tvalid_q || m_tready;
	assign in_ready = adv;

	genvar i;
	generate
		for (i = 0; i < DW; i++) begin : g_step
			logic                src_valid;
			fdm_pkg::fdm_flags_t src_flags;
			logic [DW-1:0]       src_rem;
			logic [DW-1:0]       src_quo;
			logic [DW-1:0]       src_den;
			logic [DW:0]         trial;
			logic [DW:0]         diff;
			logic                take;

			if (i == 0) begin : g_head
				assign src_valid = in_valid;
				assign src_flags = in_flags;
				assign src_rem   = '0;
				assign src_quo   = in_mag_a;
				assign src_den   = in_mag_b;
			end else begin : g_mid
				assign src_valid = valid_s[i];
				assign src_flags = flags_s[i];
				assign src_rem   = rem_s[i];
				assign src_quo   = quo_s[i];
				assign src_den   = den_s[i];
			end

			// shift in the next dividend bit and try the subtraction
			assign trial = {src_rem, src_quo[DW-1]};
			assign diff  = trial - {1'b0, src_den};
			assign take  = (trial >= {1'b0, src_den});

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s[i+1] <= 1'b0;
				end else if (adv) begin
					valid_s[i+1] <= src_valid;
				end
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					flags_s[i+1] <= src_flags;
					rem_s[i+1]   <= take ? diff[DW-1:0] : trial[DW-1:0];
					quo_s[i+1]   <= {src_quo[DW-2:0], take};
					den_s[i+1]   <= src_den;
				end
			end
		end
	endgenerate

	fdm_pkg::fdm_flags_t  fin_flags;
	logic [DW-1:0]        fin_q;
	logic [DW-1:0]        fin_r;
	logic [DW-1:0]        fin_den;
	logic [DW-1:0]        slack;
	logic signed [DW-1:0] res_q;
	logic signed [DW-1:0] res_r;

	assign fin_flags = flags_s[DW];
	assign fin_q     = quo_s[DW];
	assign fin_r     = rem_s[DW];
	assign fin_den   = den_s[DW];
	assign slack     = fin_den - fin_r;

	// signs, flooring and special cases
	always_comb begin
		if (fin_flags.div_zero) begin
			res_q = '0;
			res_r = '0;
		end else if (fin_flags.ovf) begin
			res_q = DW'(0) - fin_q;
			res_r = '0;
		end else if (fin_flags.neg_a != fin_flags.neg_b) begin
			if (fin_r != '0) begin
				// round down: quotient one below the negated magnitude
				res_q = ~fin_q;
				res_r = fin_flags.neg_b ? (DW'(0) - slack) : slack;
			end else begin
				res_q = DW'(0) - fin_q;
				res_r = '0;
			end
		end else begin
			res_q = fin_q;
			res_r = fin_flags.neg_a ? (DW'(0) - fin_r) : fin_r;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= valid_s[DW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			quotient_q <= 32'(res_q);
			modulo_q   <= 32'(res_r);
			div_zero_q <= fin_flags.div_zero;
			ovf_q      <= fin_flags.ovf;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {modulo_q, quotient_q};
	assign m_tuser  = {ovf_q, div_zero_q};

endmodule

// ===== hdl/floored_signed_divide_modulo.sv =====
// Floored signed divider: quotient and modulo at 8, 16 or wide bits.
// DW is the datapath width (the wide width, at least 16), 32 bits at the default.
// Throughput is one request per cycle while m_tready does not stall the output; the
// restoring divider has one stage per quotient bit and all stages advance together
// whenever the output register is free.
// Reset clears only the valid bits of the front, pipeline and output registers and the queue's pointers and fill level.
module floored_signed_divide_modulo #(
	parameter int MAX_WIDTH = fdm_pkg::DEF_MAX_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // dividend[31:0], divisor[63:32]
	input  logic [1:0]  s_tuser,   // width_sel[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // quotient[31:0], modulo[63:32]
	output logic [1:0]  m_tuser    // div_by_zero[0], overflow[1]
);

	localparam int DW = fdm_pkg::data_width(MAX_WIDTH);

	logic                f_valid;
	logic                f_ready;
	fdm_pkg::fdm_flags_t f_flags;
	logic [DW-1:0]       f_mag_a;
	logic [DW-1:0]       f_mag_b;

	logic                q_valid;
	logic                q_ready;
	fdm_pkg::fdm_flags_t q_flags;
	logic [DW-1:0]       q_mag_a;
	logic [DW-1:0]       q_mag_b;

	// request intake and classification
	fdm_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_flags (f_flags),
		.out_mag_a (f_mag_a),
		.out_mag_b (f_mag_b)
	);

	// decoupling queue
	fdm_fifo #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_flags  (f_flags),
		.in_mag_a  (f_mag_a),
		.in_mag_b  (f_mag_b),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_flags (q_flags),
		.out_mag_a (q_mag_a),
		.out_mag_b (q_mag_b)
	);

	// divider pipeline and result register
	fdm_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_valid),
		.in_ready (q_ready),
		.in_flags (q_flags),
		.in_mag_a (q_mag_a),
		.in_mag_b (q_mag_b),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
